// File: rtl/i2ew_pkg.sv
// Shared types and constants for the integer to English word token block.
`timescale 1ns / 1ps
`default_nettype none
package i2ew_pkg;

  localparam int ValueWidth = 31;
  localparam int WordWidth  = 5;
  localparam int NumDigits  = 10;
  localparam int BcdWidth   = 4 * NumDigits;
  localparam int CountWidth = 5;

  localparam logic [WordWidth-1:0] TOK_ZERO     = 5'd0;
  localparam logic [WordWidth-1:0] TOK_TEN      = 5'd10;
  localparam logic [WordWidth-1:0] TOK_TENS_OFS = 5'd18;
  localparam logic [WordWidth-1:0] TOK_HUNDRED  = 5'd28;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    STEP_HDIG,
    STEP_HWORD,
    STEP_TENS,
    STEP_UNIT,
    STEP_SCALE
  } step_t;

  typedef enum logic [1:0] {
    GRP_UNITS,
    GRP_THOUSANDS,
    GRP_MILLIONS,
    GRP_BILLIONS
  } group_t;

endpackage
`default_nettype wire

// File: rtl/i2ew_if.sv
// Valid/ready channel interfaces for numbers in and word tokens out.
`timescale 1ns / 1ps
`default_nettype none
interface i2ew_value_if;
  import i2ew_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2ew_word_if;
  import i2ew_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WordWidth-1:0] word;
  logic                 last;
  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/integer_to_english_word_tokens.sv
// Top level: reads a 31-bit integer out as a run of English word tokens.
//
// Usage:
//   number (sink):  one request carries a non-negative 31-bit value.
//   words (source): one token per request, last set on the final token.
//   Tokens: 0 Zero, 1-9 units, 10-19 teens, 20-27 tens, 28 Hundred,
//   29 Thousand, 30 Million, 31 Billion. Zero reads as the single token Zero.
// Operation:
//   The value is turned into ten BCD digits by double dabble, one bit per
//   cycle. A sequencer then walks the four digit groups in five steps each
//   and a closing flush step, and can stall on a busy receiver.
//   A token waits in a one-entry hold register until the next is known,
//   so that the last flag can be set; the first token leaves after the
//   second is found.
// Reset clears the sequencer, the hold register and the output register.
// A stalled receiver holds the output register and freezes the sequencer
// at its next token; a new number is taken as soon as the sequencer is
// idle, even while the final token still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_english_word_tokens (
  input  wire         clk,
  input  wire         rst,
  i2ew_value_if.sink  number,
  i2ew_word_if.source words
);
  import i2ew_pkg::*;

  state_t                state, state_next;
  step_t                 step, step_next;
  group_t                gidx, gidx_next;
  logic [CountWidth-1:0] bitcnt, bitcnt_next;
  logic [ValueWidth-1:0] shreg, shreg_next;
  logic [BcdWidth-1:0]   bcd, bcd_next;
  logic [BcdWidth-1:0]   bcd_adj;
  logic                  pend_valid, pend_valid_next;
  logic [WordWidth-1:0]  pend_word, pend_word_next;
  logic                  out_valid, out_valid_next;
  logic [WordWidth-1:0]  out_word, out_word_next;
  logic                  out_last, out_last_next;

  logic [3:0]            dig_h, dig_t, dig_u;
  logic                  gen;
  logic [WordWidth-1:0]  tok;
  logic                  out_free;

  assign number.ready = (state == ST_IDLE);
  assign words.valid  = out_valid;
  assign words.word   = out_word;
  assign words.last   = out_last;
  assign out_free     = !out_valid || words.ready;

  // Double dabble adjust: add three to every digit of five or more.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3
                                                   : bcd[4*i +: 4];
    end
  end

  // Pick the hundreds, tens and units digit of the current group.
  always_comb begin
    case (gidx)
      GRP_BILLIONS: begin
        dig_h = 4'd0;
        dig_t = 4'd0;
        dig_u = bcd[39:36];
      end
      GRP_MILLIONS: begin
        dig_h = bcd[35:32];
        dig_t = bcd[31:28];
        dig_u = bcd[27:24];
      end
      GRP_THOUSANDS: begin
        dig_h = bcd[23:20];
        dig_t = bcd[19:16];
        dig_u = bcd[15:12];
      end
      default: begin
        dig_h = bcd[11:8];
        dig_t = bcd[7:4];
        dig_u = bcd[3:0];
      end
    endcase
  end

  // Token for the current step, if the step yields one.
  always_comb begin
    gen = 1'b0;
    tok = TOK_ZERO;
    case (step)
      STEP_HDIG: begin
        gen = (dig_h != 4'd0);
        tok = {1'b0, dig_h};
      end
      STEP_HWORD: begin
        gen = (dig_h != 4'd0);
        tok = TOK_HUNDRED;
      end
      STEP_TENS: begin
        if (dig_t == 4'd1) begin
          gen = 1'b1;
          tok = TOK_TEN + {1'b0, dig_u};
        end else if (dig_t >= 4'd2) begin
          gen = 1'b1;
          tok = TOK_TENS_OFS + {1'b0, dig_t};
        end
      end
      STEP_UNIT: begin
        gen = (dig_t != 4'd1) && (dig_u != 4'd0);
        tok = {1'b0, dig_u};
      end
      STEP_SCALE: begin
        gen = ((dig_h | dig_t | dig_u) != 4'd0) && (gidx != GRP_UNITS);
        tok = TOK_HUNDRED + {3'd0, gidx};
      end
      default: begin
        gen = 1'b0;
        tok = TOK_ZERO;
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    gidx_next       = gidx;
    bitcnt_next     = bitcnt;
    shreg_next      = shreg;
    bcd_next        = bcd;
    pend_valid_next = pend_valid;
    pend_word_next  = pend_word;
    out_valid_next  = out_valid && !words.ready;
    out_word_next   = out_word;
    out_last_next   = out_last;
    case (state)
      ST_IDLE: begin
        if (number.valid) begin
          shreg_next  = number.value;
          bcd_next    = '0;
          bitcnt_next = '0;
          state_next  = ST_CONV;
        end
      end
      ST_CONV: begin
        // Adjust, then shift one bit in from the top of the value.
        bcd_next    = {bcd_adj[BcdWidth-2:0], shreg[ValueWidth-1]};
        shreg_next  = {shreg[ValueWidth-2:0], 1'b0};
        bitcnt_next = bitcnt + 1'b1;
        if (bitcnt == CountWidth'(ValueWidth - 1)) begin
          state_next = ST_EMIT;
          step_next  = STEP_HDIG;
          gidx_next  = GRP_BILLIONS;
        end
      end
      ST_EMIT: begin
        // Stall only when a new token must push the held one out and the
        // output register is still occupied.
        if (!gen || !pend_valid || out_free) begin
          if (gen) begin
            pend_valid_next = 1'b1;
            pend_word_next  = tok;
            if (pend_valid) begin
              out_valid_next = 1'b1;
              out_word_next  = pend_word;
              out_last_next  = 1'b0;
            end
          end
          case (step)
            STEP_HDIG:  step_next = STEP_HWORD;
            STEP_HWORD: step_next = STEP_TENS;
            STEP_TENS:  step_next = STEP_UNIT;
            STEP_UNIT:  step_next = STEP_SCALE;
            default: begin
              step_next = STEP_HDIG;
              if (gidx == GRP_UNITS) begin
                state_next = ST_FLUSH;
              end else begin
                gidx_next = group_t'(gidx - 2'd1);
              end
            end
          endcase
        end
      end
      ST_FLUSH: begin
        // Release the held token as the last one; nothing held means zero.
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_word_next   = pend_valid ? pend_word : TOK_ZERO;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
    step      <= step_next;
    gidx      <= gidx_next;
    bitcnt    <= bitcnt_next;
    shreg     <= shreg_next;
    bcd       <= bcd_next;
    pend_word <= pend_word_next;
    out_word  <= out_word_next;
    out_last  <= out_last_next;
  end

  // A taken number always starts the conversion.
  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    (number.valid && number.ready) |=> (state == ST_CONV))
    else $error("accepted number did not start conversion");

  // Conversion ends after exactly one pass over the value bits.
  a_conv_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && bitcnt == CountWidth'(ValueWidth - 1)) |=> (state == ST_EMIT))
    else $error("conversion did not hand over to the sequencer");

  // A held token only exists while the sequencer is reading out a number.
  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == ST_EMIT || state == ST_FLUSH))
    else $error("held token outside the readout");

  // Leaving the flush step always loads a final token.
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && out_free) |=> (out_valid && out_last && !pend_valid))
    else $error("flush did not release a last token");

endmodule
`default_nettype wire
